/* hw/rtl/bra_pkg.sv */
// Shared types, constants and helpers of the resource allocator.
`default_nettype none
package bra_pkg;
  localparam int NUM_PROCS  = 8;
  localparam int NUM_RES    = 4;
  localparam int CNT_W      = 8;
  localparam int PROC_W     = 3;
  localparam int RES_W      = 2;
  localparam int NPROC_W    = 4;
  localparam int NRES_W     = 3;
  localparam int WORK_W     = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_SETAV   = 3'd1;
  localparam logic [2:0] CMD_REQUEST = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_FAULT   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_OVER     = 3'd2;
  localparam logic [2:0] ST_FAULT    = 3'd3;
  localparam logic [2:0] ST_FSKIP    = 3'd4;

  localparam logic CFG_PROCS = 1'b0;
  localparam logic CFG_RES   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } fsm_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/bra_lane.sv */
// One resource lane of the safety scan: fit test and work accumulation.
`default_nettype none
module bra_lane (
  input  wire logic                       active,
  input  wire logic [bra_pkg::CNT_W-1:0]  need,
  input  wire logic [bra_pkg::CNT_W-1:0]  held,
  input  wire logic [bra_pkg::WORK_W-1:0] work,
  output logic                            fits,
  output logic [bra_pkg::WORK_W-1:0]      work_sum
);
  assign fits = !active ||
                ({{(bra_pkg::WORK_W-bra_pkg::CNT_W){1'b0}}, need} <= work);
  assign work_sum = active ?
                    work + {{(bra_pkg::WORK_W-bra_pkg::CNT_W){1'b0}}, held} : work;
endmodule
`default_nettype wire

/* hw/rtl/bankers_resource_allocator_unit.sv */
// Top level of the Banker's algorithm resource allocator.
// A command is taken when start is high and busy is low. Load, set available,
// release, fault, other command codes and refused requests give their result
// straight from the execute state. A request that fits is granted at once and
// then checked for safety: four resource lanes test one process row per cycle
// and a merge joins their fit flags; each pass visits the n rows in use and at
// most n passes run. Busy is high from the transfer until the result strobe.
// An unsafe grant is rolled back in the cycle that ends the check.
// Each result is shown for exactly one cycle with out_strobe high; the
// receiver cannot stall, so busy drops in the same cycle as the strobe.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while idle, as the block does not enforce it. Reset clears
// all counts and sets eight processes and four resources in use.
`default_nettype none
module bankers_resource_allocator_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_cmd,
  input  wire logic [2:0] in_process,
  input  wire logic [1:0] in_resource,
  input  wire logic [7:0] in_amount,
  input  wire logic [7:0] in_request_0,
  input  wire logic [7:0] in_request_1,
  input  wire logic [7:0] in_request_2,
  input  wire logic [7:0] in_request_3,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data,
  output logic            out_strobe,
  output logic [2:0]      out_status,
  output logic            out_unsafe_rollback,
  output logic [7:0]      out_avail_after
);
  localparam int P = bra_pkg::NUM_PROCS;
  localparam int R = bra_pkg::NUM_RES;
  localparam int C = bra_pkg::CNT_W;

  bra_pkg::fsm_t state_r, state_nxt;

  logic [bra_pkg::NPROC_W-1:0] nproc_r;
  logic [bra_pkg::NRES_W-1:0]  nres_r;
  logic [C-1:0] avail_r [R];
  logic [C-1:0] avail_nxt [R];
  logic [C-1:0] held_r [P][R];
  logic [C-1:0] need_r [P][R];
  logic [2:0]   cmd_r;
  logic [bra_pkg::PROC_W-1:0] proc_r;
  logic [bra_pkg::RES_W-1:0]  res_r;
  logic [C-1:0] amount_r;
  logic [C-1:0] req_r [R];
  logic [C-1:0] rb_held_r [R];
  logic [C-1:0] rb_need_r [R];
  logic [C-1:0] rb_held_nxt [R];
  logic [C-1:0] rb_need_nxt [R];
  logic [bra_pkg::WORK_W-1:0] work_r [R];
  logic [bra_pkg::WORK_W-1:0] work_nxt [R];
  logic [bra_pkg::WORK_W-1:0] work_sum [R];
  logic [P-1:0] done_r, done_nxt;
  logic [bra_pkg::PROC_W-1:0]  scan_r, scan_nxt;
  logic [bra_pkg::NPROC_W-1:0] left_r, left_nxt, pass_r, pass_nxt;
  logic prog_r, prog_nxt;

  logic [bra_pkg::NPROC_W-1:0] n_eff;
  logic [bra_pkg::NRES_W-1:0]  m_eff;
  logic [R-1:0] lane_act, lane_fit;
  logic [bra_pkg::PROC_W-1:0] rd_addr;
  logic [C-1:0] rd_held [R];
  logic [C-1:0] rd_need [R];
  logic row_we;
  logic [C-1:0] row_held_w [R];
  logic [C-1:0] row_need_w [R];
  logic grant_go, scan_end, scan_safe;
  logic out_strobe_nxt, out_unsafe_nxt;
  logic [2:0] out_status_nxt;
  logic accept;

  assign accept = start && (state_r == bra_pkg::S_IDLE);
  assign busy   = (state_r != bra_pkg::S_IDLE);

  assign n_eff = (nproc_r == '0) ? bra_pkg::NPROC_W'(1) :
                 (nproc_r > bra_pkg::NPROC_W'(P)) ? bra_pkg::NPROC_W'(P) : nproc_r;
  assign m_eff = (nres_r == '0) ? bra_pkg::NRES_W'(1) :
                 (nres_r > bra_pkg::NRES_W'(R)) ? bra_pkg::NRES_W'(R) : nres_r;

  assign rd_addr = (state_r == bra_pkg::S_SCAN) ? scan_r : proc_r;

  for (genvar j = 0; j < R; j++) begin : g_lane
    assign lane_act[j] = (bra_pkg::NRES_W'(j) < m_eff);
    assign rd_held[j]  = held_r[rd_addr][j];
    assign rd_need[j]  = need_r[rd_addr][j];
    bra_lane u_lane (
      .active   (lane_act[j]),
      .need     (rd_need[j]),
      .held     (rd_held[j]),
      .work     (work_r[j]),
      .fits     (lane_fit[j]),
      .work_sum (work_sum[j])
    );
  end

  // Scan bookkeeping: one process row per cycle, merge of lane fit flags.
  logic take, last_row;
  always_comb begin
    take      = !done_r[scan_r] && (&lane_fit);
    last_row  = ({1'b0, scan_r} == (n_eff - bra_pkg::NPROC_W'(1)));
    left_nxt  = left_r - bra_pkg::NPROC_W'(take);
    prog_nxt  = prog_r | take;
    pass_nxt  = pass_r;
    scan_nxt  = scan_r + bra_pkg::PROC_W'(1);
    done_nxt  = done_r;
    scan_end  = 1'b0;
    scan_safe = 1'b0;
    for (int j = 0; j < R; j++) work_nxt[j] = take ? work_sum[j] : work_r[j];
    if (take) done_nxt[scan_r] = 1'b1;
    if (last_row) begin
      pass_nxt = pass_r + bra_pkg::NPROC_W'(1);
      scan_nxt = '0;
      if (left_nxt == '0) begin
        scan_end  = 1'b1;
        scan_safe = 1'b1;
      end else if (!prog_nxt || pass_nxt == n_eff) begin
        scan_end = 1'b1;
      end
      prog_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bra_pkg::S_IDLE: if (accept) state_nxt = bra_pkg::S_EXEC;
      bra_pkg::S_EXEC: state_nxt = grant_go ? bra_pkg::S_SCAN : bra_pkg::S_IDLE;
      bra_pkg::S_SCAN: if (scan_end) state_nxt = bra_pkg::S_IDLE;
      default:         state_nxt = bra_pkg::S_IDLE;
    endcase
  end

  // Datapath and result: command execution, grant, rollback.
  logic over, shortage;
  always_comb begin
    over = 1'b0;
    shortage = 1'b0;
    grant_go = 1'b0;
    row_we = 1'b0;
    out_strobe_nxt = 1'b0;
    out_status_nxt = bra_pkg::ST_OK;
    out_unsafe_nxt = 1'b0;
    for (int j = 0; j < R; j++) begin
      avail_nxt[j]   = avail_r[j];
      row_held_w[j]  = rd_held[j];
      row_need_w[j]  = rd_need[j];
      rb_held_nxt[j] = rb_held_r[j];
      rb_need_nxt[j] = rb_need_r[j];
      if (lane_act[j] && req_r[j] > rd_need[j]) over = 1'b1;
      if (lane_act[j] && req_r[j] > avail_r[j]) shortage = 1'b1;
    end
    unique case (state_r)
      bra_pkg::S_EXEC: begin
        case (cmd_r)
          bra_pkg::CMD_LOAD: begin
            row_we = 1'b1;
            row_need_w[res_r] = (amount_r > rd_held[res_r]) ?
                                amount_r - rd_held[res_r] : '0;
            out_strobe_nxt = 1'b1;
          end
          bra_pkg::CMD_SETAV: begin
            avail_nxt[res_r] = amount_r;
            out_strobe_nxt = 1'b1;
          end
          bra_pkg::CMD_REQUEST: begin
            if (over) begin
              out_status_nxt = bra_pkg::ST_OVER;
              out_strobe_nxt = 1'b1;
            end else if (shortage) begin
              out_status_nxt = bra_pkg::ST_WAIT;
              out_strobe_nxt = 1'b1;
            end else begin
              grant_go = 1'b1;
              row_we = 1'b1;
              for (int j = 0; j < R; j++) begin
                if (lane_act[j]) begin
                  avail_nxt[j]  = avail_r[j] - req_r[j];
                  row_held_w[j] = bra_pkg::sat_add(rd_held[j], req_r[j]);
                  row_need_w[j] = rd_need[j] - req_r[j];
                end
                rb_held_nxt[j] = row_held_w[j];
                rb_need_nxt[j] = row_need_w[j];
              end
            end
          end
          bra_pkg::CMD_RELEASE: begin
            row_we = 1'b1;
            for (int j = 0; j < R; j++) begin
              avail_nxt[j]  = bra_pkg::sat_add(avail_r[j], rd_held[j]);
              row_held_w[j] = '0;
              row_need_w[j] = '0;
            end
            out_strobe_nxt = 1'b1;
          end
          bra_pkg::CMD_FAULT: begin
            if (avail_r[res_r] != '0) begin
              avail_nxt[res_r] = avail_r[res_r] - C'(1);
              out_status_nxt = bra_pkg::ST_FAULT;
            end else begin
              out_status_nxt = bra_pkg::ST_FSKIP;
            end
            out_strobe_nxt = 1'b1;
          end
          default: out_strobe_nxt = 1'b1;
        endcase
      end
      bra_pkg::S_SCAN: begin
        if (scan_end) begin
          out_strobe_nxt = 1'b1;
          if (!scan_safe) begin
            out_status_nxt = bra_pkg::ST_WAIT;
            out_unsafe_nxt = 1'b1;
            row_we = 1'b1;
            for (int j = 0; j < R; j++) begin
              row_held_w[j] = rb_held_r[j];
              row_need_w[j] = rb_need_r[j];
              if (lane_act[j]) begin
                avail_nxt[j]  = avail_r[j] + req_r[j];
                row_held_w[j] = rb_held_r[j] - req_r[j];
                row_need_w[j] = rb_need_r[j] + req_r[j];
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bra_pkg::S_IDLE;
      nproc_r    <= bra_pkg::NPROC_W'(P);
      nres_r     <= bra_pkg::NRES_W'(R);
      out_strobe <= 1'b0;
      for (int j = 0; j < R; j++) avail_r[j] <= '0;
      for (int i = 0; i < P; i++) begin
        for (int j = 0; j < R; j++) begin
          held_r[i][j] <= '0;
          need_r[i][j] <= '0;
        end
      end
    end else begin
      state_r    <= state_nxt;
      out_strobe <= out_strobe_nxt;
      if (cfg_we) begin
        if (cfg_index == bra_pkg::CFG_PROCS) nproc_r <= cfg_data;
        else nres_r <= cfg_data[bra_pkg::NRES_W-1:0];
      end
      for (int j = 0; j < R; j++) avail_r[j] <= avail_nxt[j];
      if (row_we) begin
        for (int j = 0; j < R; j++) begin
          held_r[proc_r][j] <= row_held_w[j];
          need_r[proc_r][j] <= row_need_w[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      proc_r   <= in_process;
      res_r    <= in_resource;
      amount_r <= in_amount;
      req_r[0] <= in_request_0;
      req_r[1] <= in_request_1;
      req_r[2] <= in_request_2;
      req_r[3] <= in_request_3;
    end
    for (int j = 0; j < R; j++) begin
      rb_held_r[j] <= rb_held_nxt[j];
      rb_need_r[j] <= rb_need_nxt[j];
    end
    if (grant_go) begin
      for (int j = 0; j < R; j++) work_r[j] <= {{(bra_pkg::WORK_W-C){1'b0}}, avail_nxt[j]};
      done_r <= '0;
      scan_r <= '0;
      left_r <= n_eff;
      pass_r <= '0;
      prog_r <= 1'b0;
    end else if (state_r == bra_pkg::S_SCAN) begin
      for (int j = 0; j < R; j++) work_r[j] <= work_nxt[j];
      done_r <= done_nxt;
      scan_r <= scan_nxt;
      left_r <= left_nxt;
      pass_r <= pass_nxt;
      prog_r <= prog_nxt;
    end
    if (out_strobe_nxt) begin
      out_status          <= out_status_nxt;
      out_unsafe_rollback <= out_unsafe_nxt;
      out_avail_after     <= avail_nxt[res_r];
    end
  end

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a command in progress");
  a_unsafe_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_unsafe_rollback) |-> (out_status == bra_pkg::ST_WAIT))
    else $error("rollback reported with a status other than wait");
  a_scan_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bra_pkg::S_SCAN) |-> (cmd_r == bra_pkg::CMD_REQUEST))
    else $error("safety scan running for a command other than request");
endmodule
`default_nettype wire

/* bench/tb_bankers_resource_allocator_unit.sv */
// Self-checking testbench of the Banker's algorithm resource allocator.
`timescale 1ns / 1ps
`default_nettype none

class alloc_scoreboard;
  logic [3:0] procs_cfg;
  logic [2:0] res_cfg;
  logic [7:0] avail [4];
  logic [7:0] held [8][4];
  logic [7:0] need [8][4];
  logic [2:0] exp_status [$];
  logic exp_unsafe [$];
  logic [7:0] exp_avail [$];
  int errors;

  function new();
    procs_cfg = 4'd8;
    res_cfg = 3'd4;
    errors = 0;
    for (int j = 0; j < 4; j++) begin
      avail[j] = '0;
      for (int i = 0; i < 8; i++) begin
        held[i][j] = '0;
        need[i][j] = '0;
      end
    end
  endfunction

  function void write_cfg(logic idx, logic [3:0] data);
    if (idx == bra_pkg::CFG_PROCS) procs_cfg = data;
    else res_cfg = data[2:0];
  endfunction

  function int n_procs();
    if (procs_cfg < 1) return 1;
    if (procs_cfg > 8) return 8;
    return procs_cfg;
  endfunction

  function int n_res();
    if (res_cfg < 1) return 1;
    if (res_cfg > 4) return 4;
    return res_cfg;
  endfunction

  function bit is_safe();
    int work [4];
    bit done [8];
    int n, m, left;
    bit progress, fits;
    n = n_procs();
    m = n_res();
    left = n;
    for (int j = 0; j < 4; j++) work[j] = avail[j];
    for (int i = 0; i < 8; i++) done[i] = 0;
    for (int pass = 0; pass < n && left > 0; pass++) begin
      progress = 0;
      for (int i = 0; i < n; i++) begin
        if (!done[i]) begin
          fits = 1;
          for (int j = 0; j < m; j++) if (need[i][j] > work[j]) fits = 0;
          if (fits) begin
            for (int j = 0; j < m; j++) work[j] += held[i][j];
            done[i] = 1;
            left--;
            progress = 1;
          end
        end
      end
      if (!progress) break;
    end
    return left == 0;
  endfunction

  function void note_command(logic [2:0] cmd, logic [2:0] p, logic [1:0] r,
                             logic [7:0] amt, logic [7:0] req [4]);
    logic [2:0] st;
    logic uns;
    bit over, short;
    int m;
    logic [8:0] s;
    st = bra_pkg::ST_OK;
    uns = 0;
    m = n_res();
    case (cmd)
      bra_pkg::CMD_LOAD: need[p][r] = amt > held[p][r] ? amt - held[p][r] : 8'd0;
      bra_pkg::CMD_SETAV: avail[r] = amt;
      bra_pkg::CMD_REQUEST: begin
        over = 0;
        short = 0;
        for (int j = 0; j < m; j++) begin
          if (req[j] > need[p][j]) over = 1;
          if (req[j] > avail[j]) short = 1;
        end
        if (over) st = bra_pkg::ST_OVER;
        else if (short) st = bra_pkg::ST_WAIT;
        else begin
          for (int j = 0; j < m; j++) begin
            avail[j] -= req[j];
            s = held[p][j] + req[j];
            held[p][j] = s[8] ? 8'hFF : s[7:0];
            need[p][j] -= req[j];
          end
          if (!is_safe()) begin
            for (int j = 0; j < m; j++) begin
              avail[j] += req[j];
              held[p][j] -= req[j];
              need[p][j] += req[j];
            end
            st = bra_pkg::ST_WAIT;
            uns = 1;
          end
        end
      end
      bra_pkg::CMD_RELEASE: begin
        for (int j = 0; j < 4; j++) begin
          s = avail[j] + held[p][j];
          avail[j] = s[8] ? 8'hFF : s[7:0];
          held[p][j] = '0;
          need[p][j] = '0;
        end
      end
      bra_pkg::CMD_FAULT: begin
        if (avail[r] > 0) begin
          avail[r]--;
          st = bra_pkg::ST_FAULT;
        end else st = bra_pkg::ST_FSKIP;
      end
      default: ;
    endcase
    exp_status.push_back(st);
    exp_unsafe.push_back(uns);
    exp_avail.push_back(avail[r]);
  endfunction

  function void check_result(logic [2:0] st, logic uns, logic [7:0] av);
    if (exp_status.size() == 0) begin
      $display("%0t: unexpected result status=%0d", $realtime, st);
      errors++;
      return;
    end
    if (st !== exp_status[0]) begin
      $display("%0t: status expected %0d actual %0d", $realtime, exp_status[0], st);
      errors++;
    end
    if (uns !== exp_unsafe[0]) begin
      $display("%0t: unsafe_rollback expected %0d actual %0d", $realtime,
               exp_unsafe[0], uns);
      errors++;
    end
    if (av !== exp_avail[0]) begin
      $display("%0t: avail_after expected %0d actual %0d", $realtime, exp_avail[0], av);
      errors++;
    end
    void'(exp_status.pop_front());
    void'(exp_unsafe.pop_front());
    void'(exp_avail.pop_front());
  endfunction
endclass

module tb_bankers_resource_allocator_unit;
  logic clk, rst_n, start, busy;
  logic [2:0] in_cmd, in_process;
  logic [1:0] in_resource;
  logic [7:0] in_amount, in_request_0, in_request_1, in_request_2, in_request_3;
  logic cfg_we, cfg_index;
  logic [3:0] cfg_data;
  logic out_strobe, out_unsafe_rollback;
  logic [2:0] out_status;
  logic [7:0] out_avail_after;

  alloc_scoreboard board;
  bit gaps_on;

  bankers_resource_allocator_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_process(in_process), .in_resource(in_resource),
    .in_amount(in_amount), .in_request_0(in_request_0), .in_request_1(in_request_1),
    .in_request_2(in_request_2), .in_request_3(in_request_3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_unsafe_rollback(out_unsafe_rollback), .out_avail_after(out_avail_after)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      board.check_result(out_status, out_unsafe_rollback, out_avail_after);
  end

  task automatic issue(logic [2:0] cmd, logic [2:0] p, logic [1:0] r, logic [7:0] amt,
                       logic [7:0] r0, logic [7:0] r1, logic [7:0] r2, logic [7:0] r3);
    logic [7:0] req [4];
    req = '{r0, r1, r2, r3};
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(posedge clk);
    start <= 1;
    in_cmd <= cmd;
    in_process <= p;
    in_resource <= r;
    in_amount <= amt;
    in_request_0 <= r0;
    in_request_1 <= r1;
    in_request_2 <= r2;
    in_request_3 <= r3;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(cmd, p, r, amt, req);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.exp_status.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] data);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_cfg(idx, data);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_item(int scale);
    int k;
    logic [7:0] lim, third, amt;
    logic [2:0] c, p;
    logic [1:0] r;
    logic [7:0] q [4];
    k = $urandom_range(0, 99);
    lim = scale[7:0];
    third = lim / 8'd3;
    c = 3'($urandom);
    p = 3'($urandom);
    r = 2'($urandom);
    amt = 8'($urandom);
    for (int j = 0; j < 4; j++) q[j] = 8'($urandom);
    if (k < 15)
      issue(bra_pkg::CMD_LOAD, p, r, 8'($urandom_range(0, lim)), q[0], q[1], q[2], q[3]);
    else if (k < 25)
      issue(bra_pkg::CMD_SETAV, p, r, 8'($urandom_range(0, lim)), q[0], q[1], q[2], q[3]);
    else if (k < 75)
      issue(bra_pkg::CMD_REQUEST, p, r, amt, 8'($urandom_range(0, third)),
            8'($urandom_range(0, third)), 8'($urandom_range(0, third)),
            8'($urandom_range(0, third)));
    else if (k < 85)
      issue(bra_pkg::CMD_RELEASE, p, r, amt, q[0], q[1], q[2], q[3]);
    else if (k < 95)
      issue(bra_pkg::CMD_FAULT, p, r, amt, q[0], q[1], q[2], q[3]);
    else
      issue(c, p, r, amt, q[0], q[1], q[2], q[3]);
  endtask

  initial begin
    board = new();
    gaps_on = 0;
    rst_n = 0;
    start = 0;
    in_cmd = '0;
    in_process = '0;
    in_resource = '0;
    in_amount = '0;
    in_request_0 = '0;
    in_request_1 = '0;
    in_request_2 = '0;
    in_request_3 = '0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    issue(bra_pkg::CMD_FAULT, 0, 0, 0, 0, 0, 0, 0);
    issue(bra_pkg::CMD_SETAV, 0, 0, 8'hFF, 0, 0, 0, 0);
    issue(bra_pkg::CMD_SETAV, 0, 1, 8'd10, 0, 0, 0, 0);
    issue(bra_pkg::CMD_SETAV, 0, 2, 8'd5, 0, 0, 0, 0);
    issue(bra_pkg::CMD_SETAV, 0, 3, 8'd0, 0, 0, 0, 0);
    issue(bra_pkg::CMD_LOAD, 7, 0, 8'hFF, 0, 0, 0, 0);
    issue(bra_pkg::CMD_LOAD, 7, 1, 8'd20, 0, 0, 0, 0);
    issue(bra_pkg::CMD_REQUEST, 7, 0, 0, 8'hFF, 0, 0, 0);
    issue(bra_pkg::CMD_REQUEST, 7, 1, 0, 0, 8'd21, 0, 0);
    issue(bra_pkg::CMD_REQUEST, 7, 1, 0, 0, 8'd15, 0, 0);
    issue(bra_pkg::CMD_LOAD, 0, 1, 8'd10, 0, 0, 0, 0);
    issue(bra_pkg::CMD_REQUEST, 0, 1, 0, 0, 8'd10, 0, 0);
    issue(bra_pkg::CMD_LOAD, 7, 1, 8'd0, 0, 0, 0, 0);
    issue(bra_pkg::CMD_FAULT, 0, 2, 0, 0, 0, 0, 0);
    issue(bra_pkg::CMD_RELEASE, 7, 0, 0, 0, 0, 0, 0);
    issue(bra_pkg::CMD_RELEASE, 0, 1, 0, 0, 0, 0, 0);
    issue(3'd5, 0, 0, 0, 0, 0, 0, 0);
    issue(3'd7, 7, 3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    gaps_on = 1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(bra_pkg::CFG_PROCS, 4'd8); write_reg(bra_pkg::CFG_RES, 4'd4); end
        1: begin write_reg(bra_pkg::CFG_PROCS, 4'd1); write_reg(bra_pkg::CFG_RES, 4'd1); end
        2: begin write_reg(bra_pkg::CFG_PROCS, 4'd0); write_reg(bra_pkg::CFG_RES, 4'd0); end
        3: begin write_reg(bra_pkg::CFG_PROCS, 4'd15); write_reg(bra_pkg::CFG_RES, 4'd7); end
        4: begin write_reg(bra_pkg::CFG_PROCS, 4'($urandom_range(2, 7)));
                 write_reg(bra_pkg::CFG_RES, 4'($urandom_range(2, 3))); end
        default: begin
          write_reg(bra_pkg::CFG_PROCS, 4'd8);
          write_reg(bra_pkg::CFG_RES, 4'd4);
        end
      endcase
      if (ph == 5) gaps_on = 0;
      for (int i = 0; i < 240; i++) random_item(ph == 3 ? 255 : 30);
    end

    drain();
    if (board.errors == 0 && board.exp_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
